### hw/rtl/aes_block_encrypt_top_defines.svh
// Assertion macros shared by the checker file.
`ifndef AES_BLOCK_ENCRYPT_TOP_DEFINES_SVH
`define AES_BLOCK_ENCRYPT_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### hw/rtl/aes_pkg.sv
// Package with AES constants, tables and round functions.
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;
  localparam int unsigned NumStages = 15;
  localparam int unsigned Rounds128 = 10;
  localparam int unsigned Rounds256 = 14;

  typedef enum logic [2:0] {
    CFG_MODE = 3'd0,
    CFG_KEY0 = 3'd1,
    CFG_KEY1 = 3'd2,
    CFG_KEY2 = 3'd3,
    CFG_KEY3 = 3'd4
  } cfg_idx_t;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] blk_t;
  typedef logic [255:0] key_t;

  // One pipeline slot: state, the running 256-bit key window, mode.
  typedef struct packed {
    logic  vld;
    logic  mode;
    blk_t  st;
    key_t  kw;
    byte_t rc;
  } slot_t;

  function automatic byte_t sbox(input byte_t x);
    byte_t t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic byte_t xtime(input byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Byte b of the block sits at bits 8b+7:8b.
  function automatic blk_t sub_shift(input blk_t s);
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[8*(r+4*c) +: 8] = sbox(s[8*(r+4*((c+r)%4)) +: 8]);
      end
    end
    return o;
  endfunction

  function automatic blk_t mix_cols(input blk_t s);
    blk_t o;
    byte_t a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      o[32*c +: 8]    = a0 ^ al ^ xtime(a0 ^ a1);
      o[32*c+8 +: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      o[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      o[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return o;
  endfunction

  // Rotated substitution of a word, byte 0 lowest.
  function automatic logic [31:0] rot_sub(input logic [31:0] w);
    return {sbox(w[7:0]), sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8])};
  endfunction

  // Next four schedule words from the four words one key length back and the
  // newest schedule word p, with rotation and the round constant.
  function automatic blk_t next128(input blk_t k, input logic [31:0] p, input byte_t rc);
    blk_t o;
    o[31:0]   = k[31:0] ^ rot_sub(p) ^ {24'd0, rc};
    o[63:32]  = k[63:32] ^ o[31:0];
    o[95:64]  = k[95:64] ^ o[63:32];
    o[127:96] = k[127:96] ^ o[95:64];
    return o;
  endfunction

  // AES-256 half step that uses plain substitution.
  function automatic blk_t next256b(input blk_t k, input logic [31:0] p);
    blk_t o;
    o[31:0]   = k[31:0] ^ sub_word(p);
    o[63:32]  = k[63:32] ^ o[31:0];
    o[95:64]  = k[95:64] ^ o[63:32];
    o[127:96] = k[127:96] ^ o[95:64];
    return o;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/aes_block_encrypt_top.sv
// Top level of the pipelined AES-128/AES-256 encryption engine.
`timescale 1ns / 1ps
`default_nettype none
// One round per register stage, fifteen stages in all, the round keys being
// expanded alongside the data in each stage. A request is taken in every
// cycle while the output can move; every ciphertext passes through all the
// stages, which hold the fourteen rounds of AES-256 plus the first key
// addition (AES-128 blocks pass the last four stages unchanged, so the
// order of results always follows the order of requests). The whole pipeline
// advances only when its last stage is empty or being taken, so a stall on
// the output holds every request in place. in_tdata holds plain_low in bits
// 63:0 and plain_high in 127:64; out_tdata likewise. Configuration must be
// written only while the pipeline is empty.
module aes_block_encrypt_top
  import aes_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // plain_low, plain_high
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,  // cipher_low, cipher_high
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_idx,
  input  wire logic [63:0]  cfg_wdata
);
  localparam int unsigned STAGES = NumStages;

  logic        mode_r;
  logic [63:0] key_r [4];
  slot_t       pipe_r [STAGES];
  slot_t       pipe_nxt [STAGES];
  logic        adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MODE: mode_r   <= cfg_wdata[0];
        CFG_KEY0: key_r[0] <= cfg_wdata;
        CFG_KEY1: key_r[1] <= cfg_wdata;
        CFG_KEY2: key_r[2] <= cfg_wdata;
        CFG_KEY3: key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv       = !pipe_r[STAGES-1].vld || out_tready;
  assign in_tready = adv;

  // Stage 0 adds the first round key. For AES-256 the upper half of the key
  // window holds the newest four schedule words and the lower half the four
  // before them; for AES-128 only the lower half is used.
  always_comb begin
    key_t k;
    blk_t nk;
    k = mode_r ? {key_r[3], key_r[2], key_r[1], key_r[0]}
               : {128'd0, key_r[1], key_r[0]};
    pipe_nxt[0].vld  = in_tvalid;
    pipe_nxt[0].mode = mode_r;
    pipe_nxt[0].st   = in_tdata ^ k[127:0];
    pipe_nxt[0].kw   = k;
    pipe_nxt[0].rc   = 8'h01;
    for (int s = 1; s < STAGES; s++) begin
      slot_t p;
      logic  last, act;
      blk_t  rk;
      p = pipe_r[s-1];
      pipe_nxt[s] = p;
      last = p.mode ? (s == Rounds256) : (s == Rounds128);
      act  = p.mode ? 1'b1 : (s <= Rounds128);
      if (p.mode) begin
        // Round s uses schedule words 4s..4s+3.
        if (s == 1) begin
          rk = p.kw[255:128];
          nk = '0;
        end else if (s % 2 == 0) begin
          nk = next128(p.kw[127:0], p.kw[255:224], p.rc);
          rk = nk;
          pipe_nxt[s].kw = {nk, p.kw[255:128]};
          pipe_nxt[s].rc = xtime(p.rc);
        end else begin
          nk = next256b(p.kw[127:0], p.kw[255:224]);
          rk = nk;
          pipe_nxt[s].kw = {nk, p.kw[255:128]};
        end
      end else begin
        rk = next128(p.kw[127:0], p.kw[127:96], p.rc);
        nk = '0;
        pipe_nxt[s].kw = {128'd0, rk};
        pipe_nxt[s].rc = xtime(p.rc);
      end
      if (act) begin
        pipe_nxt[s].st = last ? (sub_shift(p.st) ^ rk)
                              : (mix_cols(sub_shift(p.st)) ^ rk);
      end else begin
        pipe_nxt[s].st = p.st;
      end
      if (!act) pipe_nxt[s].kw = p.kw;
    end
  end

  // Only the valid bits are reset; the data follows them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) pipe_r[s].vld <= 1'b0;
    end else if (adv) begin
      for (int s = 0; s < STAGES; s++) pipe_r[s] <= pipe_nxt[s];
    end
  end

  assign out_tvalid = pipe_r[STAGES-1].vld;
  assign out_tdata  = pipe_r[STAGES-1].st;
endmodule
`default_nettype wire

### hw/rtl/aes_chk.sv
// Port checker for the encryption engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "aes_block_encrypt_top_defines.svh"
module aes_chk (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata
);
  `AES_ASSERT_IMP(a_ready_when_free, clk, rst_n, !out_tvalid, in_tready)
  `AES_ASSERT_IMP(a_ready_follows_out, clk, rst_n, out_tvalid, in_tready == out_tready)
  `AES_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata))
endmodule
bind aes_block_encrypt_top aes_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

### tb/sv/aes_block_encrypt_top_test.sv
// Self-checking testbench for the pipelined AES-128/AES-256 encryption engine.
`timescale 1ns / 1ps
module aes_block_encrypt_top_test;
  import aes_pkg::*;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } blk128_t;

  localparam int unsigned PipeDepth = 15;
  localparam int unsigned HoldLimit = 20000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_idx = '0;
  logic [63:0]  cfg_wdata = '0;

  // Our own copy of the key registers, mirrored on every write.
  logic        mode_256;
  logic [63:0] key_words [4];

  // Plaintext requests waiting for the driver and ciphertexts still owed.
  blk128_t plain_queue [$];
  blk128_t cipher_queue [$];

  int  error_count = 0;
  int  idle_cycles = 0;
  bit  idle_enable = 1'b1;
  int  hold_cycles = 0;
  bit  timed_out = 1'b0;
  bit  in_taken = 1'b0;

  always #2 clk = ~clk;

  aes_block_encrypt_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  function automatic logic [7:0] sbox_lookup(input logic [7:0] x);
    // Built from the field inverse and affine map so that no table is copied.
    logic [7:0] inv, p, b, r;
    inv = 8'h00;
    for (int c = 1; c < 256; c++) begin
      p = 8'h00;
      b = 8'(c);
      r = x;
      for (int k = 0; k < 8; k++) begin
        if (b[0]) p ^= r;
        b = b >> 1;
        r = {r[6:0], 1'b0} ^ (r[7] ? 8'h1b : 8'h00);
      end
      if (p == 8'h01) inv = 8'(c);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
               ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  logic [7:0] sbox_tab [256];
  initial for (int i = 0; i < 256; i++) sbox_tab[i] = sbox_lookup(8'(i));

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Forward cipher of one block under the mirrored key.
  function automatic blk128_t encrypt_block(input blk128_t plain);
    logic [7:0] sched [240];
    logic [7:0] st [16];
    logic [7:0] old [16];
    logic [7:0] t [4];
    logic [7:0] tmp, rc, a0, a1, a2, a3, al;
    int nk, nr;
    blk128_t res;
    nk = mode_256 ? 8 : 4;
    nr = mode_256 ? 14 : 10;
    for (int i = 0; i < 4 * nk; i++) sched[i] = key_words[i / 8][8 * (i % 8) +: 8];
    rc = 8'h01;
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      for (int b = 0; b < 4; b++) t[b] = sched[4 * (i - 1) + b];
      if (i % nk == 0) begin
        tmp = t[0];
        t[0] = sbox_tab[t[1]] ^ rc;
        t[1] = sbox_tab[t[2]];
        t[2] = sbox_tab[t[3]];
        t[3] = sbox_tab[tmp];
        rc = gf_double(rc);
      end else if (nk == 8 && i % nk == 4) begin
        for (int b = 0; b < 4; b++) t[b] = sbox_tab[t[b]];
      end
      for (int b = 0; b < 4; b++) sched[4 * i + b] = sched[4 * (i - nk) + b] ^ t[b];
    end
    for (int i = 0; i < 16; i++) st[i] = plain[8 * i +: 8] ^ sched[i];
    for (int rnd = 1; rnd <= nr; rnd++) begin
      old = st;
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) st[r + 4 * c] = sbox_tab[old[r + 4 * ((c + r) % 4)]];
      if (rnd != nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          st[4*c]   = a0 ^ al ^ gf_double(a0 ^ a1);
          st[4*c+1] = a1 ^ al ^ gf_double(a1 ^ a2);
          st[4*c+2] = a2 ^ al ^ gf_double(a2 ^ a3);
          st[4*c+3] = a3 ^ al ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] ^= sched[16 * rnd + i];
    end
    for (int i = 0; i < 16; i++) res[8 * i +: 8] = st[i];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  // Register write, made on the falling edge and taken at the next rising one.
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE: mode_256 = value[0];
      CFG_KEY0: key_words[0] = value;
      CFG_KEY1: key_words[1] = value;
      CFG_KEY2: key_words[2] = value;
      CFG_KEY3: key_words[3] = value;
      default: ;
    endcase
  endtask

  // Driver: one request at a time out of the pending queue, with random idling.
  // A request stays on the bus until the monitor has seen it accepted.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (plain_queue.size() > 0 && !(idle_enable && $urandom_range(99) < 19)) begin
          in_tvalid <= 1'b1;
          in_tdata <= plain_queue[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: a long hold-off when asked for, else random stalls.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && !(idle_enable && $urandom_range(99) < 19);
    end
  end

  // Monitor: every accepted ciphertext is checked against the oldest owed one.
  // The expected ciphertext is worked out when the request is accepted, so the
  // key in force is always the one the block used.
  // The watchdog counts cycles with no transfer, no register write and no hold-off.
  always @(posedge clk) begin
    blk128_t want;
    blk128_t got;
    in_taken = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (cipher_queue.size() == 0) begin
          report_mismatch("unexpected cipher_low", got.lo, '0);
        end else begin
          want = cipher_queue.pop_front();
          if (got.lo !== want.lo) report_mismatch("cipher_low", got.lo, want.lo);
          if (got.hi !== want.hi) report_mismatch("cipher_high", got.hi, want.hi);
        end
      end
      if (in_taken) begin
        cipher_queue.push_back(encrypt_block(plain_queue.pop_front()));
      end
      if ((out_tvalid && out_tready) || in_taken || cfg_we || hold_cycles > 0)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > HoldLimit && !timed_out) timed_out <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random plaintext; a share of blocks take extreme or sparse patterns.
  function automatic blk128_t random_plain();
    blk128_t p;
    case ($urandom_range(9))
      0: p = '0;
      1: p = '1;
      2: p = 128'd1 << $urandom_range(127);
      default: p = {rand64(), rand64()};
    endcase
    return p;
  endfunction

  // Waits until the block has returned everything, then lets the pipeline drain.
  task automatic wait_drained();
    while (plain_queue.size() > 0 || in_tvalid || cipher_queue.size() > 0) @(negedge clk);
    repeat (PipeDepth + 4) @(negedge clk);
  endtask

  task automatic load_key(input logic m, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    write_reg(CFG_MODE, {63'd0, m});
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
  endtask

  initial begin
    mode_256 = 1'b0;
    for (int i = 0; i < 4; i++) key_words[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Before any key write the all-zero key is in force.
    plain_queue.push_back('0);
    plain_queue.push_back('1);
    wait_drained();

    // Standard AES-128 example vector, then field extremes.
    load_key(1'b0, 64'h0f0e0d0c0b0a0908 ^ 64'h0f0e0d0c0b0a0908 ^ 64'h0706050403020100,
             64'h0f0e0d0c0b0a0908, 64'hffffffffffffffff, 64'h123456789abcdef0);
    plain_queue.push_back({64'hffeeddccbbaa9988, 64'h7766554433221100});
    plain_queue.push_back('0);
    plain_queue.push_back('1);
    plain_queue.push_back({64'h0, 64'hffffffffffffffff});
    plain_queue.push_back({64'hffffffffffffffff, 64'h0});
    wait_drained();

    // AES-256 with a counting key, extremes, and a mode value with upper bits set.
    load_key(1'b1, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
             64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
    plain_queue.push_back({64'hffeeddccbbaa9988, 64'h7766554433221100});
    plain_queue.push_back('1);
    wait_drained();
    write_reg(CFG_MODE, 64'hfffffffffffffffe);
    plain_queue.push_back({64'hffeeddccbbaa9988, 64'h7766554433221100});
    wait_drained();
    load_key(1'b1, '1, '1, '1, '1);
    plain_queue.push_back('0);
    plain_queue.push_back('1);
    wait_drained();

    // Long receiver hold-off while requests keep coming, so the pipeline fills.
    for (int i = 0; i < 60; i++) plain_queue.push_back(random_plain());
    hold_cycles = 200;
    wait_drained();

    // Random phases under changing keys; one phase runs with no idling.
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: load_key(1'b0, '0, '0, '1, '1);
        1: load_key(1'b1, '0, '0, '0, '0);
        default: load_key(1'($urandom_range(1)), rand64(), rand64(), rand64(), rand64());
      endcase
      idle_enable = (phase != 5);
      for (int i = 0; i < 140; i++) plain_queue.push_back(random_plain());
      // The sender pauses here until every ciphertext has come back.
      wait_drained();
    end
    idle_enable = 1'b1;

    if (error_count == 0 && cipher_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
